[rtl/pli_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types, constants and command/status structs for the interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int MAX_KNOTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_DIRECT = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LAST,
    S_LOAD_CHK,
    S_DIV,
    S_DIV_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_EV_RD,
    S_EV_MUL,
    S_EV_ADD,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;      // latch input item
    logic rd_last;      // read entry count-1
    logic div_start;    // init divider
    logic div_step;     // one divider iteration
    logic wr_knot;      // write x,y at count, bump count
    logic wr_slope;     // write slope at count-1 and the tail slope
    logic srch_init;
    logic srch_rd;      // read x at mid
    logic srch_cmp;     // narrow lo/hi
    logic ev_rd;        // read slope/x/y at idx
    logic ev_mul;
    logic ev_add;
    logic set_order;
    logic clear_tbl;    // first knot: reset count and order flag
    logic set_result;   // latch result with given status
    logic [1:0] res_status;
    logic res_zero;     // result value 0
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       first;
    logic       full;      // count >= MAX_KNOTS
    logic       empty;     // count == 0
    logic       few;       // count < 3
    logic       x_bad;     // x <= last x
    logic       div_done;
    logic       srch_done;
    logic       order_err;
  } stat_t;

endpackage
`default_nettype wire

[rtl/pli_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_datapath
// Knot tables, serial divider, binary search registers and evaluator.
// ----------------------------------------------------------------------------
module pli_datapath #(
  parameter int MAX_KNOTS = pli_pkg::MAX_KNOTS_DEF,
  parameter int FRAC_BITS = pli_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pli_pkg::cmd_t       cmd,
  output pli_pkg::stat_t           stat,
  input  wire logic [1:0]          func,
  input  wire logic                first_knot,
  input  wire logic signed [31:0]  point_x,
  input  wire logic signed [31:0]  point_y,
  input  wire logic [5:0]          segment_index,
  input  wire logic signed [31:0]  base_x,
  input  wire logic signed [31:0]  base_y,
  output logic signed [31:0]       value,
  output logic [1:0]               status,
  output logic                     saturated
);
  localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int CW = $clog2(MAX_KNOTS + 1);
  localparam int NW = 33 + FRAC_BITS;   // dividend magnitude width
  localparam int DCW = $clog2(NW + 1);

  logic signed [31:0] knot_xs [MAX_KNOTS];
  logic signed [31:0] knot_ys [MAX_KNOTS];
  logic signed [31:0] slopes  [MAX_KNOTS];

  logic [CW-1:0] knot_count;
  logic          order_error;
  // slope of the last knot, a copy of the one before it
  logic signed [31:0] tail_slope;

  // captured item
  logic [1:0]         r_func;
  logic               r_first;
  logic signed [31:0] r_px, r_py, r_bx, r_by;
  logic [5:0]         r_seg;

  // binary search
  logic [CW-1:0] lo, hi, mid;
  logic [CW-1:0] ev_idx;
  assign mid = CW'(({1'b0, lo} + {1'b0, hi}) >> 1);

  // table read registers
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_x, rd_y, rd_s;
  logic [AW-1:0]      wr_addr;

  always_comb begin
    rd_addr = '0;
    if (cmd.rd_last) begin
      rd_addr = AW'(knot_count - CW'(1));
    end else if (cmd.srch_rd) begin
      rd_addr = AW'(mid);
    end else begin
      rd_addr = AW'(ev_idx);
    end
  end

  // a first knot goes to entry 0 while the count clears
  assign wr_addr = cmd.clear_tbl ? '0 : AW'(knot_count);

  always_ff @(posedge clk) begin
    rd_x <= knot_xs[rd_addr];
    rd_y <= knot_ys[rd_addr];
    rd_s <= slopes[rd_addr];
  end

  // serial restoring divider on magnitudes
  logic [NW-1:0]  dquot;
  logic [33:0]    drem;
  logic [32:0]    ddiv;
  logic           dneg;
  logic [DCW-1:0] dcnt;
  logic signed [32:0] dx_w, dy_w;
  logic [32:0]    dy_mag;
  logic [33:0]    rem_sh;

  assign dx_w   = 33'(r_px) - 33'(rd_x);
  assign dy_w   = 33'(r_py) - 33'(rd_y);
  assign dy_mag = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
  assign rem_sh = {drem[32:0], dquot[NW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dquot <= NW'({dy_mag, {FRAC_BITS{1'b0}}});
      drem  <= '0;
      ddiv  <= dx_w;
      dneg  <= dy_w[32];
      dcnt  <= DCW'(NW);
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, ddiv}) begin
        drem  <= rem_sh - {1'b0, ddiv};
        dquot <= {dquot[NW-2:0], 1'b1};
      end else begin
        drem  <= rem_sh;
        dquot <= {dquot[NW-2:0], 1'b0};
      end
      dcnt <= dcnt - DCW'(1);
    end
  end

  logic signed [NW:0] sq;
  logic signed [31:0] slope_sat;
  assign sq = dneg ? -$signed({1'b0, dquot}) : $signed({1'b0, dquot});
  always_comb begin
    if (sq > $signed((NW+1)'(32'sh7fffffff))) begin
      slope_sat = 32'sh7fffffff;
    end else if (sq < -$signed((NW+1)'(33'h080000000))) begin
      slope_sat = 32'sh80000000;
    end else begin
      slope_sat = sq[31:0];
    end
  end

  // evaluator
  logic signed [31:0] bsy;
  logic signed [64:0] prod;
  logic signed [64:0] q;
  logic signed [64:0] qc, sum;
  logic signed [32:0] h_now;
  logic signed [31:0] slope_use;
  logic signed [64:0] prod_next;

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      lo <= '0;
      hi <= knot_count;
    end else if (cmd.srch_cmp) begin
      if (r_px > rd_x) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
    end
  end

  always_comb begin
    if (r_func == pli_pkg::FUNC_SEARCH) begin
      ev_idx = (lo > '0) ? lo - CW'(1) : '0;
    end else if (CW'(r_seg) < knot_count && r_seg <= 6'(MAX_KNOTS - 1)) begin
      ev_idx = CW'(r_seg);
    end else begin
      ev_idx = knot_count - CW'(1);
    end
  end

  // offset from the segment start: read x if search, else base x
  assign h_now = (r_func == pli_pkg::FUNC_SEARCH) ? 33'(r_px) - 33'(rd_x)
                                                 : 33'(r_px) - 33'(r_bx);
  assign slope_use = (ev_idx == knot_count - CW'(1)) ? tail_slope : rd_s;
  assign prod_next = 65'(slope_use) * 65'(h_now);

  always_ff @(posedge clk) begin
    if (cmd.ev_mul) begin
      prod <= prod_next;
      bsy  <= (r_func == pli_pkg::FUNC_SEARCH) ? rd_y : r_by;
    end
  end

  assign q  = prod >>> FRAC_BITS;
  always_comb begin
    qc = q;
    if (q > 65'sd1099511627776) begin
      qc = 65'sd1099511627776;
    end else if (q < -65'sd1099511627776) begin
      qc = -65'sd1099511627776;
    end
    sum = qc + 65'(bsy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count  <= '0;
      order_error <= 1'b0;
    end else begin
      if (cmd.wr_knot) begin
        knot_count <= cmd.clear_tbl ? CW'(1) : knot_count + CW'(1);
      end else if (cmd.clear_tbl) begin
        knot_count <= '0;
      end
      if (cmd.clear_tbl) begin
        order_error <= 1'b0;
      end else if (cmd.set_order) begin
        order_error <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_knot) begin
      knot_xs[wr_addr] <= r_px;
      knot_ys[wr_addr] <= r_py;
    end
    if (cmd.wr_slope) begin
      slopes[AW'(knot_count - CW'(1))] <= slope_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_slope) begin
      tail_slope <= slope_sat;
    end else if (cmd.wr_knot) begin
      tail_slope <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_func  <= func;
      r_first <= first_knot;
      r_px    <= point_x;
      r_py    <= point_y;
      r_seg   <= segment_index;
      r_bx    <= base_x;
      r_by    <= base_y;
    end
    if (cmd.set_result) begin
      status <= cmd.res_status;
      if (cmd.res_zero) begin
        value     <= '0;
        saturated <= 1'b0;
      end else if (sum > 65'sd2147483647) begin
        value     <= 32'sh7fffffff;
        saturated <= 1'b1;
      end else if (sum < -65'sd2147483648) begin
        value     <= 32'sh80000000;
        saturated <= 1'b1;
      end else begin
        value     <= sum[31:0];
        saturated <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.func      = r_func;
    stat.first     = r_first;
    stat.full      = knot_count >= CW'(MAX_KNOTS);
    stat.empty     = knot_count == '0;
    stat.few       = knot_count < CW'(3);
    stat.x_bad     = r_px <= rd_x;
    stat.div_done  = dcnt == '0;
    stat.srch_done = lo >= hi;
    stat.order_err = order_error;
  end
endmodule
`default_nettype wire

[rtl/pli_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer for load, search and direct evaluation.
// ----------------------------------------------------------------------------
module pli_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  output logic                done,
  output pli_pkg::cmd_t       cmd,
  input  wire pli_pkg::stat_t stat
);
  pli_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pli_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pli_pkg::S_IDLE: begin
        if (start) state_next = pli_pkg::S_RD_LAST;
      end
      pli_pkg::S_RD_LAST: begin
        if (stat.func == pli_pkg::FUNC_LOAD) begin
          if (stat.full && !stat.first) state_next = pli_pkg::S_DONE;
          else if (stat.empty || stat.first) state_next = pli_pkg::S_DONE;
          else state_next = pli_pkg::S_LOAD_CHK;
        end else if (stat.func == pli_pkg::FUNC_SEARCH && !stat.few) begin
          state_next = pli_pkg::S_SRCH_RD;
        end else if (stat.func == pli_pkg::FUNC_DIRECT && !stat.few) begin
          state_next = pli_pkg::S_EV_RD;
        end else begin
          state_next = pli_pkg::S_DONE;
        end
      end
      pli_pkg::S_LOAD_CHK: begin
        state_next = stat.x_bad ? pli_pkg::S_DONE : pli_pkg::S_DIV;
      end
      pli_pkg::S_DIV: begin
        if (stat.div_done) state_next = pli_pkg::S_DIV_WR;
      end
      pli_pkg::S_DIV_WR:  state_next = pli_pkg::S_DONE;
      pli_pkg::S_SRCH_RD: begin
        state_next = stat.srch_done ? pli_pkg::S_EV_RD : pli_pkg::S_SRCH_CMP;
      end
      pli_pkg::S_SRCH_CMP: state_next = pli_pkg::S_SRCH_RD;
      pli_pkg::S_EV_RD:    state_next = pli_pkg::S_EV_MUL;
      pli_pkg::S_EV_MUL:   state_next = pli_pkg::S_EV_ADD;
      pli_pkg::S_EV_ADD:   state_next = pli_pkg::S_DONE;
      pli_pkg::S_DONE:     state_next = pli_pkg::S_IDLE;
      default:             state_next = pli_pkg::S_IDLE;
    endcase
  end

  // first knot / empty loads are decided without a table read
  always_comb begin
    cmd  = '0;
    busy = state != pli_pkg::S_IDLE;
    done = state == pli_pkg::S_DONE;
    case (state)
      pli_pkg::S_IDLE: begin
        cmd.capture = start;
      end
      pli_pkg::S_RD_LAST: begin
        cmd.rd_last   = 1'b1;
        cmd.srch_init = 1'b1;
        cmd.res_zero  = 1'b1;
        if (stat.func == pli_pkg::FUNC_LOAD) begin
          cmd.clear_tbl = stat.first;
          if (stat.full && !stat.first) begin
            cmd.set_result = 1'b1;
            cmd.res_status = pli_pkg::ST_FULL;
          end else if (stat.empty || stat.first) begin
            cmd.wr_knot    = 1'b1;
            cmd.set_result = 1'b1;
            cmd.res_status = pli_pkg::ST_OK;
          end
        end else if (stat.few) begin
          cmd.set_result = 1'b1;
          cmd.res_status = (stat.func == pli_pkg::FUNC_SEARCH ||
                            stat.func == pli_pkg::FUNC_DIRECT) ? pli_pkg::ST_FEW
                                                               : pli_pkg::ST_OK;
        end else if (stat.func != pli_pkg::FUNC_SEARCH &&
                     stat.func != pli_pkg::FUNC_DIRECT) begin
          cmd.set_result = 1'b1;
          cmd.res_status = pli_pkg::ST_OK;
        end
      end
      pli_pkg::S_LOAD_CHK: begin
        cmd.div_start = 1'b1;
        cmd.res_zero  = 1'b1;
        if (stat.x_bad) begin
          cmd.set_order  = 1'b1;
          cmd.set_result = 1'b1;
          cmd.res_status = pli_pkg::ST_ORDER;
        end
      end
      pli_pkg::S_DIV: begin
        cmd.div_step = !stat.div_done;
      end
      pli_pkg::S_DIV_WR: begin
        cmd.wr_knot    = 1'b1;
        cmd.wr_slope   = 1'b1;
        cmd.set_result = 1'b1;
        cmd.res_zero   = 1'b1;
        cmd.res_status = pli_pkg::ST_OK;
      end
      pli_pkg::S_SRCH_RD:  cmd.srch_rd  = 1'b1;
      pli_pkg::S_SRCH_CMP: cmd.srch_cmp = 1'b1;
      pli_pkg::S_EV_RD:    cmd.ev_rd    = 1'b1;
      pli_pkg::S_EV_MUL:   cmd.ev_mul   = 1'b1;
      pli_pkg::S_EV_ADD: begin
        cmd.ev_add     = 1'b1;
        cmd.set_result = 1'b1;
        cmd.res_status = stat.order_err ? pli_pkg::ST_ORDER : pli_pkg::ST_OK;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[rtl/piecewise_linear_interpolator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Every item starts in RD_LAST and ends in DONE. A first or full-table load, too
// few knots or the unused code has nothing between; an out-of-order load adds
// LOAD_CHK; a load with the slope divide adds LOAD_CHK, DIV (33+FRAC_BITS quotient
// bits, one per cycle) and DIV_WR; a search adds SRCH_RD/SRCH_CMP per halving step,
// then EV_RD, EV_MUL, EV_ADD; direct has only those. A new item waits for busy to
// drop after done; receiver cannot stall. rst clears knot count and order flag.
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Fixed-point knot table with linear interpolation and extrapolation.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
  parameter int MAX_KNOTS = pli_pkg::MAX_KNOTS_DEF,
  parameter int FRAC_BITS = pli_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done,
  input  wire logic [1:0]         func,
  input  wire logic               first_knot,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic [5:0]         segment_index,
  input  wire logic signed [31:0] base_x,
  input  wire logic signed [31:0] base_y,
  output logic signed [31:0]      value,
  output logic [1:0]              status,
  output logic                    saturated
);
  pli_pkg::cmd_t  cmd;
  pli_pkg::stat_t stat;

  pli_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cmd(cmd), .stat(stat)
  );

  pli_datapath #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .func(func), .first_knot(first_knot), .point_x(point_x),
    .point_y(point_y), .segment_index(segment_index), .base_x(base_x),
    .base_y(base_y), .value(value), .status(status), .saturated(saturated)
  );
endmodule
`default_nettype wire

[tb/piecewise_linear_interpolator_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_checker
// Watches command and result transfers of the interpolator, keeps its own copy
// of the knot table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               done,
  input  logic [1:0]         func,
  input  logic               first_knot,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic [5:0]         segment_index,
  input  logic signed [31:0] base_x,
  input  logic signed [31:0] base_y,
  input  logic signed [31:0] value,
  input  logic [1:0]         status,
  input  logic               saturated,
  output int                 fails,
  output int                 pending,
  output int                 n_results,
  output int                 n_sat,
  output int                 n_full
);
  import pli_pkg::*;

  localparam int NKNOTS = MAX_KNOTS_DEF;
  localparam int FBITS  = FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               saturated;
  } interp_result_t;

  logic signed [31:0] tbl_x [NKNOTS];
  logic signed [31:0] tbl_y [NKNOTS];
  logic signed [31:0] tbl_slope [NKNOTS];
  logic [6:0]         num_knots;
  logic               order_flag;

  interp_result_t expected_results [$];

  function automatic logic signed [31:0] clip_q16(input longint v, inout logic sat);
    if (v > longint'(32'sh7fffffff)) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -longint'(64'sd2147483648)) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // slope * h with floor scaling, plus base, saturated
  function automatic logic signed [31:0] eval_line(input logic signed [31:0] slope,
                                                   input longint h, input longint base,
                                                   inout logic sat);
    longint prod;
    longint q;
    prod = longint'(slope) * h;
    q = prod >>> FBITS;
    if (q > (64'sd1 <<< 40)) q = 64'sd1 <<< 40;
    if (q < -(64'sd1 <<< 40)) q = -(64'sd1 <<< 40);
    return clip_q16(q + base, sat);
  endfunction

  task automatic interpolate(input logic [1:0] f, input logic fk, input logic signed [31:0] px,
                             input logic signed [31:0] py, input logic [5:0] seg,
                             input logic signed [31:0] bx, input logic signed [31:0] by,
                             output interp_result_t r);
    longint dx;
    longint dy;
    int     n;
    int     idx;
    int     below;
    logic   sat;
    logic   dummy;
    r = '0;
    sat = 1'b0;
    dummy = 1'b0;
    if (f == FUNC_LOAD) begin
      if (fk) begin
        num_knots = '0;
        order_flag = 1'b0;
      end
      n = num_knots;
      if (n >= NKNOTS) begin
        r.status = ST_FULL;
      end else if (n > 0 && px <= tbl_x[n-1]) begin
        order_flag = 1'b1;
        r.status = ST_ORDER;
      end else begin
        tbl_x[n] = px;
        tbl_y[n] = py;
        if (n == 0) begin
          tbl_slope[0] = '0;
        end else begin
          dx = longint'(px) - longint'(tbl_x[n-1]);
          dy = longint'(py) - longint'(tbl_y[n-1]);
          tbl_slope[n-1] = clip_q16((dy <<< FBITS) / dx, dummy);
          tbl_slope[n] = tbl_slope[n-1];
        end
        num_knots = 7'(n + 1);
      end
    end else if (f == FUNC_SEARCH || f == FUNC_DIRECT) begin
      n = num_knots;
      if (n < 3) begin
        r.status = ST_FEW;
      end else begin
        if (f == FUNC_SEARCH) begin
          // table is sorted: count of knots strictly below x gives the segment
          below = 0;
          for (int i = 0; i < n; i++) if (tbl_x[i] < px) below++;
          idx = (below > 0) ? below - 1 : 0;
          r.value = eval_line(tbl_slope[idx], longint'(px) - longint'(tbl_x[idx]),
                              longint'(tbl_y[idx]), sat);
        end else begin
          idx = (seg < n) ? seg : n - 1;
          r.value = eval_line(tbl_slope[idx], longint'(px) - longint'(bx),
                              longint'(by), sat);
        end
        r.saturated = sat;
        r.status = order_flag ? ST_ORDER : ST_OK;
      end
    end
  endtask

  assign pending = expected_results.size();

  always @(posedge clk) begin
    interp_result_t exp_r;
    if (rst) begin
      num_knots <= '0;
      order_flag <= 1'b0;
      fails = 0;
      n_results = 0;
      n_sat = 0;
      n_full = 0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: value %h status %0d sat %0b",
                   $time, value, status, saturated);
          fails++;
        end else begin
          exp_r = expected_results.pop_front();
          n_results++;
          if (exp_r.saturated) n_sat++;
          if (exp_r.status == ST_FULL) n_full++;
          if (value !== exp_r.value) begin
            $display("%0t: value mismatch: expected %h actual %h", $time, exp_r.value, value);
            fails++;
          end
          if (status !== exp_r.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time, exp_r.status,
                     status);
            fails++;
          end
          if (saturated !== exp_r.saturated) begin
            $display("%0t: saturated mismatch: expected %0b actual %0b", $time,
                     exp_r.saturated, saturated);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        interpolate(func, first_knot, point_x, point_y, segment_index, base_x, base_y, exp_r);
        expected_results.push_back(exp_r);
      end
    end
  end
endmodule

[tb/tb_piecewise_linear_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_interpolator
// Builds knot tables and queries for the interpolator under several sender
// idle patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interpolator;
  import pli_pkg::*;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               done;
  logic [1:0]         func;
  logic               first_knot;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [5:0]         segment_index;
  logic signed [31:0] base_x;
  logic signed [31:0] base_y;
  logic signed [31:0] value;
  logic [1:0]         status;
  logic               saturated;

  int fails;
  int pending;
  int n_results;
  int n_sat;
  int n_full;
  int idle_pct;
  int n_items;

  // x values of the table as loaded so far, for building queries
  longint knot_list [$];

  piecewise_linear_interpolator i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .func(func), .first_knot(first_knot), .point_x(point_x), .point_y(point_y),
    .segment_index(segment_index), .base_x(base_x), .base_y(base_y),
    .value(value), .status(status), .saturated(saturated)
  );

  piecewise_linear_interpolator_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .func(func), .first_knot(first_knot), .point_x(point_x), .point_y(point_y),
    .segment_index(segment_index), .base_x(base_x), .base_y(base_y),
    .value(value), .status(status), .saturated(saturated),
    .fails(fails), .pending(pending), .n_results(n_results), .n_sat(n_sat),
    .n_full(n_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("tb_piecewise_linear_interpolator NOT OK");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic [1:0] f, input logic fk, input longint px,
                           input longint py, input logic [5:0] seg,
                           input longint bx, input longint by);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    func = f;
    first_knot = fk;
    point_x = px[31:0];
    point_y = py[31:0];
    segment_index = seg;
    base_x = bx[31:0];
    base_y = by[31:0];
    while (busy) @(negedge clk);
    @(negedge clk);
    start = 1'b0;
    n_items++;
  endtask

  function automatic longint rand32();
    return longint'($signed($urandom()));
  endfunction

  task automatic load_knot(input logic fk, input longint px, input longint py);
    if (fk) knot_list.delete();
    if (knot_list.size() < MAX_KNOTS_DEF &&
        (knot_list.size() == 0 || px > knot_list[$]))
      knot_list.push_back(px);
    send_item(FUNC_LOAD, fk, px, py, 6'($urandom()), rand32(), rand32());
  endtask

  function automatic longint query_x();
    longint lo;
    longint hi;
    if (knot_list.size() == 0) return rand32();
    lo = knot_list[0];
    hi = knot_list[$];
    case ($urandom_range(5))
      0: return rand32();
      1: return knot_list[$urandom_range(knot_list.size() - 1)];
      2: return lo - $urandom_range(1000);
      3: return (hi + $urandom_range(1000) > 64'sd2147483647) ? hi : hi + $urandom_range(1000);
      default: return lo + longint'($urandom()) % (hi - lo + 1);
    endcase
  endfunction

  task automatic evaluate();
    if ($urandom_range(1))
      send_item(FUNC_SEARCH, 1'($urandom()), query_x(), rand32(), 6'($urandom()),
                rand32(), rand32());
    else
      send_item(FUNC_DIRECT, 1'($urandom()), query_x(), rand32(), 6'($urandom()),
                $urandom_range(1) ? rand32() : query_x(), rand32());
  endtask

  // one table with random content (a knot may break the order), then mostly queries
  task automatic build_table(input int nk);
    longint x;
    longint y;
    longint step;
    x = ($urandom_range(3) == 0) ? rand32() : longint'($signed($urandom())) >>> 8;
    y = rand32();
    for (int i = 0; i < nk; i++) begin
      if (i > 0) begin
        case ($urandom_range(3))
          0: step = $urandom_range(1, 255);
          1: step = $urandom_range(1, 1 << 20);
          2: step = $urandom_range(1, 1 << 30);
          default: step = $urandom_range(1, 1 << 14);
        endcase
        if ($urandom_range(19) == 0) step = -longint'($urandom_range(16)); // broken order
        if (x + step > 64'sd2147483647) step = 64'sd2147483647 - x;
        x = x + step;
        y = $urandom_range(3) == 0 ? rand32() : y + longint'($signed($urandom())) % 65536;
        if (y > 64'sd2147483647 || y < -64'sd2147483648) y = rand32();
      end
      load_knot(i == 0, x, y);
    end
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(19))
        0: send_item(2'd3, 1'($urandom()), rand32(), rand32(), 6'($urandom()), rand32(),
                     rand32());
        1: load_knot(1'b0, query_x(), rand32());
        default: evaluate();
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_LOAD;
    first_knot = 1'b0;
    point_x = '0;
    point_y = '0;
    segment_index = '0;
    base_x = '0;
    base_y = '0;
    idle_pct = 0;
    n_items = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: too few knots, extremes, clamping, order error, unused code
    send_item(FUNC_SEARCH, 1'b0, 0, 0, 0, 0, 0);
    load_knot(1'b1, -64'sd2147483648, -64'sd2147483648);
    load_knot(1'b0, 0, 64'sd2147483647);
    send_item(FUNC_DIRECT, 1'b1, 5, 0, 6'd63, 0, 0);
    load_knot(1'b0, 1, -64'sd2147483648);
    load_knot(1'b0, 64'sd2147483647, 64'sd2147483647);
    send_item(FUNC_SEARCH, 1'b0, -64'sd2147483648, 0, 0, 0, 0);
    send_item(FUNC_SEARCH, 1'b0, 64'sd2147483647, 0, 0, 0, 0);
    send_item(FUNC_SEARCH, 1'b0, 0, 0, 0, 0, 0);
    send_item(FUNC_SEARCH, 1'b0, 1, 0, 0, 0, 0);
    send_item(FUNC_DIRECT, 1'b0, 64'sd2147483647, -1, 6'd63, -64'sd2147483648,
              64'sd2147483647);
    send_item(FUNC_DIRECT, 1'b0, -64'sd2147483648, -1, 6'd1, 64'sd2147483647,
              -64'sd2147483648);
    send_item(FUNC_DIRECT, 1'b0, 0, 0, 6'd0, 0, 0);
    load_knot(1'b0, 64'sd2147483647, 0);
    send_item(FUNC_SEARCH, 1'b0, 100, 0, 0, 0, 0);
    send_item(2'd3, 1'b1, -1, -1, 6'd63, -1, -1);
    load_knot(1'b1, 0, 0);
    load_knot(1'b0, 65536, 65536);
    load_knot(1'b0, 131072, -65536);
    send_item(FUNC_SEARCH, 1'b0, 98304, 0, 0, 0, 0);
    send_item(FUNC_SEARCH, 1'b0, -65536, 0, 0, 0, 0);
    send_item(FUNC_DIRECT, 1'b0, 32768, 0, 6'd2, 0, 12345);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 73;
        2: idle_pct = 34;
        default: idle_pct = 0;
      endcase
      while (n_items < 22 + (phase + 1) * 240) begin
        case ($urandom_range(15))
          0: build_table(MAX_KNOTS_DEF + $urandom_range(2));
          1, 2: build_table($urandom_range(1, 2));
          default: build_table($urandom_range(3, 8));
        endcase
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    $display("%0d items sent, %0d results checked (%0d saturated, %0d table-full)",
             n_items, n_results, n_sat, n_full);
    if (fails == 0 && pending == 0) begin
      $display("tb_piecewise_linear_interpolator OK");
    end else begin
      $display("tb_piecewise_linear_interpolator NOT OK");
    end
    $finish;
  end
endmodule
